[src/cpd_pkg.sv]
// Package for the CRC-32 packet deframer.
// Holds the result item type, status codes, header constants and the CRC byte update.
// No dependencies.
package cpd_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 4096;
  localparam int unsigned HEADER_BYTES     = 12;
  localparam int unsigned FIFO_DEPTH       = 4;

  localparam logic [7:0]  MAGIC_FIRST     = 8'h51;
  localparam logic [7:0]  MAGIC_SECOND    = 8'h4B;
  localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES        = 32'hFFFFFFFF;
  localparam logic [12:0] FRAME_BYTES_RST = 13'd4096;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_BAD_LEN   = 2'd2,
    ST_BAD_CRC   = 2'd3
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  data_byte;
    logic [11:0] payload_length;
    logic [31:0] sequence_res;
    logic [1:0]  status;
    logic        end_of_packet;
  } item_t;

  typedef struct packed {
    logic [1:0] cnt;
    item_t      first;
    item_t      second;
  } push_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

[src/cpd_out_fifo.sv]
// Result queue of the CRC-32 packet deframer: takes up to two items per cycle.
// Depends on cpd_pkg.
module cpd_out_fifo
  import cpd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t head
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  item_t         mem_r [FIFO_DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (count_r <= CW'(FIFO_DEPTH - 2));
  assign head      = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r + AW'(push.cnt);
    rptr_nxt  = rptr_r + AW'(pop);
    count_nxt = count_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wptr_r + AW'(1)] <= push.second;
    end
  end

endmodule

[src/crc32_packet_deframer.sv]
// Top level of the CRC-32 packet deframer: header capture, CRC check, status.
// Depends on cpd_pkg and cpd_out_fifo.
//
// Usage:
//  - in_*: one received byte per transaction, packets of frame_bytes bytes back to back.
//  - out_*: one result per transaction. Payload bytes go out as they arrive
//    (item_kind 0); the last byte of a packet also yields a status item
//    (item_kind 1, end_of_packet 1) after its payload item, if any.
//  - cfg_*: writes frame_bytes, always ready; write only while the block is idle.
// Each result is written into the result queue when its byte is accepted.
// Throughput: one byte per cycle. The header, CRC and status logic finish in the
// accept cycle; a four-entry result queue absorbs the second result of a
// packet's last byte. in_ready drops while fewer than two queue entries are free.
// A stalled receiver fills the queue and then holds off the input.
// Reset (rst_n low, synchronous) empties the queue, restarts at the first
// header byte and sets frame_bytes to 4096.
module crc32_packet_deframer
  import cpd_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MAX_PACKET_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_item_kind,
  output logic [7:0]  out_data_byte,
  output logic [11:0] out_payload_length,
  output logic [31:0] out_sequence_res,
  output logic [1:0]  out_status,
  output logic        out_end_of_packet,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_frame_bytes
);

  localparam int PW = $clog2(MAX_BYTES);
  localparam int CW = ((PW > 16) ? PW : 16) + 1;

  logic [12:0]   frame_r;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [31:0]   crc_r, crc_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [31:0]   seq_r, seq_nxt;
  logic [31:0]   rcrc_r, rcrc_nxt;
  logic          magic_r, magic_nxt;

  logic          accept;
  logic          room;
  logic [CW-1:0] p_ext, fsz;
  logic          hdr, payload, last;
  status_t       st;
  push_t         push;
  item_t         head;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign in_ready  = room;

  always_comb begin
    fsz = CW'(frame_r);
    if (fsz < CW'(HEADER_BYTES + 1)) begin
      fsz = CW'(HEADER_BYTES + 1);
    end else if (fsz > CW'(MAX_BYTES)) begin
      fsz = CW'(MAX_BYTES);
    end
  end

  always_comb begin
    p_ext     = CW'(pos_r);
    hdr       = (p_ext < CW'(HEADER_BYTES));
    payload   = !hdr && (p_ext < CW'(HEADER_BYTES) + CW'(len_r));
    last      = (p_ext + CW'(1) >= fsz);
    magic_nxt = magic_r;
    len_nxt   = len_r;
    seq_nxt   = seq_r;
    rcrc_nxt  = rcrc_r;
    crc_nxt   = crc_r;
    if (hdr) begin
      unique case (pos_r[3:0])
        4'd0:    if (in_rx_byte != MAGIC_FIRST) magic_nxt = 1'b0;
        4'd1:    if (in_rx_byte != MAGIC_SECOND) magic_nxt = 1'b0;
        4'd2:    len_nxt[7:0]    = in_rx_byte;
        4'd3:    len_nxt[15:8]   = in_rx_byte;
        4'd4:    seq_nxt[7:0]    = in_rx_byte;
        4'd5:    seq_nxt[15:8]   = in_rx_byte;
        4'd6:    seq_nxt[23:16]  = in_rx_byte;
        4'd7:    seq_nxt[31:24]  = in_rx_byte;
        4'd8:    rcrc_nxt[7:0]   = in_rx_byte;
        4'd9:    rcrc_nxt[15:8]  = in_rx_byte;
        4'd10:   rcrc_nxt[23:16] = in_rx_byte;
        4'd11:   rcrc_nxt[31:24] = in_rx_byte;
        default: ;
      endcase
      crc_nxt = crc32_byte(crc_r, pos_r[3] ? 8'd0 : in_rx_byte);
    end else if (payload) begin
      crc_nxt = crc32_byte(crc_r, in_rx_byte);
    end

    priority if (!magic_nxt) begin
      st = ST_BAD_MAGIC;
    end else if ((len_nxt == 16'd0) || (CW'(len_nxt) > fsz - CW'(HEADER_BYTES))) begin
      st = ST_BAD_LEN;
    end else if ((crc_nxt ^ CRC_ONES) != rcrc_nxt) begin
      st = ST_BAD_CRC;
    end else begin
      st = ST_OK;
    end

    pos_nxt = pos_r + PW'(1);
  end

  always_comb begin
    item_t pay_item;
    item_t st_item;
    pay_item                = '0;
    pay_item.item_kind      = KIND_PAYLOAD;
    pay_item.data_byte      = in_rx_byte;
    st_item                 = '0;
    st_item.item_kind       = KIND_STATUS;
    st_item.payload_length  = (st == ST_OK) ? len_nxt[11:0] : 12'd0;
    st_item.sequence_res    = seq_nxt;
    st_item.status          = st;
    st_item.end_of_packet   = 1'b1;
    push.cnt                = 2'd0;
    push.first              = st_item;
    push.second             = st_item;
    if (accept) begin
      if (payload) begin
        push.first = pay_item;
        push.cnt   = last ? 2'd2 : 2'd1;
      end else if (last) begin
        push.cnt   = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= FRAME_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      frame_r <= cfg_frame_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      crc_r   <= CRC_ONES;
      len_r   <= '0;
      seq_r   <= '0;
      rcrc_r  <= '0;
      magic_r <= 1'b1;
    end else if (accept) begin
      if (last) begin
        pos_r   <= '0;
        crc_r   <= CRC_ONES;
        len_r   <= '0;
        seq_r   <= '0;
        rcrc_r  <= '0;
        magic_r <= 1'b1;
      end else begin
        pos_r   <= pos_nxt;
        crc_r   <= crc_nxt;
        len_r   <= len_nxt;
        seq_r   <= seq_nxt;
        rcrc_r  <= rcrc_nxt;
        magic_r <= magic_nxt;
      end
    end
  end

  cpd_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_item_kind      = head.item_kind;
  assign out_data_byte      = head.data_byte;
  assign out_payload_length = head.payload_length;
  assign out_sequence_res   = head.sequence_res;
  assign out_status         = head.status;
  assign out_end_of_packet  = head.end_of_packet;

endmodule

[src/cpd_checker.sv]
// Port-level checks for the CRC-32 packet deframer, bound to the top level.
// Depends on cpd_pkg and crc32_packet_deframer.
module cpd_checker
  import cpd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_item_kind,
  input logic [7:0]  out_data_byte,
  input logic [11:0] out_payload_length,
  input logic [31:0] out_sequence_res,
  input logic [1:0]  out_status,
  input logic        out_end_of_packet
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item_kind)
      && $stable(out_data_byte) && $stable(out_sequence_res) && $stable(out_status))
    else $error("stalled transaction changed");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_kind == KIND_PAYLOAD) |-> !out_end_of_packet
      && (out_status == ST_OK) && (out_payload_length == 12'd0) && (out_sequence_res == 32'd0))
    else $error("payload item carries status fields");

  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_kind == KIND_STATUS) |-> out_end_of_packet
      && (out_data_byte == 8'd0))
    else $error("malformed status item");

  a_fail_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_packet && (out_status != ST_OK) |-> (out_payload_length == 12'd0))
    else $error("failed packet reports a length");

endmodule

bind crc32_packet_deframer cpd_checker u_cpd_checker (.*);

[dv/tb_crc32_packet_deframer.sv]
// Testbench for crc32_packet_deframer: streams framed byte packets through the block and
// checks every payload byte and end-of-packet status against a built-in deframing predictor.
// Depends on cpd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb_crc32_packet_deframer;
  import cpd_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES  = 2000;
  localparam int unsigned LONG_HOLD_CYCLES = 120;
  localparam int unsigned RANDOM_BYTES     = 640;

  typedef enum int {
    FLAW_NONE,
    FLAW_MAGIC,
    FLAW_LENGTH,
    FLAW_CRC,
    FLAW_NOISE
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_item_kind;
  logic [7:0]  out_data_byte;
  logic [11:0] out_payload_length;
  logic [31:0] out_sequence_res;
  logic [1:0]  out_status;
  logic        out_end_of_packet;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [12:0] cfg_frame_bytes = 13'd0;

  logic [7:0]  rx_backlog[$];
  item_t       due_results[$];
  item_t       want;

  logic [12:0] frame_reg = FRAME_BYTES_RST;
  int unsigned pos = 0;
  logic [31:0] run_crc = CRC_ONES;
  logic [15:0] len_field = 16'd0;
  logic [31:0] seq_field = 32'd0;
  logic [31:0] rx_crc = 32'd0;
  logic        magic_ok = 1'b1;

  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  logic        cfg_fire = 1'b0;
  bit          burst = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          in_gap = 0;
  int          out_wait = 0;
  int          long_hold = 0;
  int unsigned queued_bytes = 0;
  int unsigned accepted_bytes = 0;
  int unsigned payload_count = 0;
  int unsigned status_count[4] = '{0, 0, 0, 0};
  int unsigned idle_cycles = 0;
  int          errors = 0;

  crc32_packet_deframer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_item_kind     (out_item_kind),
    .out_data_byte     (out_data_byte),
    .out_payload_length(out_payload_length),
    .out_sequence_res  (out_sequence_res),
    .out_status        (out_status),
    .out_end_of_packet (out_end_of_packet),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_frame_bytes   (cfg_frame_bytes)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    int unsigned fsz;
    item_t       it;
    fsz = 32'(frame_reg);
    if (fsz < HEADER_BYTES + 1) fsz = HEADER_BYTES + 1;
    if (fsz > MAX_PACKET_BYTES) fsz = MAX_PACKET_BYTES;
    if (pos < HEADER_BYTES) begin
      case (pos)
        0: if (b != MAGIC_FIRST) magic_ok = 1'b0;
        1: if (b != MAGIC_SECOND) magic_ok = 1'b0;
        2, 3: len_field[8*(pos-2) +: 8] = b;
        4, 5, 6, 7: seq_field[8*(pos-4) +: 8] = b;
        default: rx_crc[8*(pos-8) +: 8] = b;
      endcase
      run_crc = crc_update(run_crc, (pos >= 8) ? 8'h00 : b);
    end else if (pos < HEADER_BYTES + len_field) begin
      run_crc = crc_update(run_crc, b);
      it = '0;
      it.item_kind = KIND_PAYLOAD;
      it.data_byte = b;
      due_results.push_back(it);
    end
    if (pos + 1 >= fsz) begin
      it = '0;
      it.item_kind = KIND_STATUS;
      it.end_of_packet = 1'b1;
      it.sequence_res = seq_field;
      if (!magic_ok) begin
        it.status = ST_BAD_MAGIC;
      end else if (len_field == 0 || len_field > fsz - HEADER_BYTES) begin
        it.status = ST_BAD_LEN;
      end else if (~run_crc != rx_crc) begin
        it.status = ST_BAD_CRC;
      end else begin
        it.status = ST_OK;
        it.payload_length = len_field[11:0];
      end
      due_results.push_back(it);
      pos = 0;
      run_crc = CRC_ONES;
      len_field = '0;
      seq_field = '0;
      rx_crc = '0;
      magic_ok = 1'b1;
    end else begin
      pos++;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  task automatic queue_packet(input int unsigned fsz, input logic [15:0] len,
                              input flaw_t flaw, input int unsigned keep);
    logic [7:0]  pkt[$];
    logic [95:0] hdr;
    logic [31:0] c;
    int unsigned stop;
    int unsigned n;
    int unsigned sel;
    bit          pad_noise;
    if (flaw == FLAW_NOISE) begin
      for (int i = 0; i < fsz; i++) pkt.push_back(8'($urandom));
    end else begin
      hdr = {32'd0, $urandom, len, MAGIC_SECOND, MAGIC_FIRST};
      if (flaw == FLAW_MAGIC) begin
        sel = $urandom_range(0, 2);
        if (sel != 1) hdr[7:0] = hdr[7:0] ^ 8'($urandom_range(1, 255));
        if (sel != 0) hdr[15:8] = hdr[15:8] ^ 8'($urandom_range(1, 255));
      end
      for (int i = 0; i < HEADER_BYTES; i++) pkt.push_back(hdr[8*i +: 8]);
      pad_noise = ($urandom_range(0, 7) == 0);
      for (int i = HEADER_BYTES; i < fsz; i++) begin
        if (i < HEADER_BYTES + len || pad_noise) pkt.push_back(8'($urandom));
        else pkt.push_back(8'h00);
      end
      stop = (HEADER_BYTES + len < fsz) ? HEADER_BYTES + len : fsz;
      c = CRC_ONES;
      for (int i = 0; i < stop; i++) c = crc_update(c, (i >= 8 && i < 12) ? 8'h00 : pkt[i]);
      c = ~c;
      if (flaw == FLAW_CRC) c = c ^ (32'h1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) pkt[8+i] = c[8*i +: 8];
    end
    n = (keep != 0) ? keep : pkt.size();
    for (int i = 0; i < n; i++) rx_backlog.push_back(pkt[i]);
    queued_bytes += n;
  endtask

  task automatic write_frame(input logic [12:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_frame_bytes <= value;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (accepted_bytes != queued_bytes || due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Driver: hold the byte until its transaction, then advance after the drawn gap.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (rx_backlog.size() != 0) begin
        in_valid <= 1'b1;
        in_rx_byte <= rx_backlog.pop_front();
        in_gap = burst ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: per-result stall, plus one long hold-off.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req && !hold_done) begin
        long_hold = LONG_HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (out_fire) out_wait = burst ? 0 : $urandom_range(0, 4);
      if (long_hold > 0) begin
        long_hold--;
        out_ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each input transaction, compare each result transaction.
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    out_fire <= out_valid && out_ready;
    cfg_fire <= cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) frame_reg = cfg_frame_bytes;
      if (in_valid && in_ready) begin
        deframe_byte(in_rx_byte);
        accepted_bytes++;
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none actual kind %0h data %0h status %0h",
                   $time, out_item_kind, out_data_byte, out_status);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("item_kind", want.item_kind, out_item_kind);
          check_field("data_byte", want.data_byte, out_data_byte);
          check_field("payload_length", want.payload_length, out_payload_length);
          check_field("sequence_res", want.sequence_res, out_sequence_res);
          check_field("status", want.status, out_status);
          check_field("end_of_packet", want.end_of_packet, out_end_of_packet);
          if (want.item_kind == KIND_STATUS) status_count[want.status]++;
          else payload_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_CYCLES) begin
        $display("%0t ns: watchdog, no transaction in %0d cycles", $time, WATCHDOG_CYCLES);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned fsz;
    int unsigned base_bytes;
    int unsigned npk;
    int unsigned pick;
    logic [12:0] cfg_word;
    logic [15:0] len;
    flaw_t       flaw;
    bit          first_phase;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Out-of-range low frame size, shortest legal packet.
    write_frame(13'd0);
    @(posedge clk);
    queue_packet(13, 16'd1, FLAW_NONE, 0);
    drain();

    // Shrink the frame in mid-packet so the next byte closes it.
    write_frame(13'd20);
    @(posedge clk);
    queue_packet(20, 16'd3, FLAW_NONE, 15);
    drain();
    write_frame(13'd13);
    @(posedge clk);
    rx_backlog.push_back(8'hFF);
    queued_bytes++;
    drain();

    // Out-of-range high frame size, longest payload cut short by a shrink.
    write_frame(13'h1FFF);
    @(posedge clk);
    burst = ($urandom_range(0, 1) == 0);
    queue_packet(MAX_PACKET_BYTES, 16'(MAX_PACKET_BYTES - HEADER_BYTES), FLAW_NONE, 48);
    drain();
    write_frame(13'd13);
    @(posedge clk);
    rx_backlog.push_back(8'h00);
    queued_bytes++;
    drain();

    base_bytes = queued_bytes;
    first_phase = 1'b1;
    while (queued_bytes - base_bytes < RANDOM_BYTES) begin
      case ($urandom_range(0, 3))
        0: fsz = 13;
        1: fsz = $urandom_range(14, 40);
        2: fsz = 64;
        default: fsz = $urandom_range(13, 120);
      endcase
      if (first_phase) fsz = 64;
      cfg_word = 13'(fsz);
      if (fsz == 13 && $urandom_range(0, 1) == 1) cfg_word = 13'($urandom_range(0, 12));
      write_frame(cfg_word);
      @(posedge clk);
      burst = first_phase || ($urandom_range(0, 3) == 0);
      npk = first_phase ? 4 : $urandom_range(2, 6);
      for (int k = 0; k < npk; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) flaw = FLAW_NONE;
        else if (pick == 6) flaw = FLAW_MAGIC;
        else if (pick == 7) flaw = FLAW_LENGTH;
        else if (pick == 8) flaw = FLAW_CRC;
        else flaw = FLAW_NOISE;
        if (flaw == FLAW_LENGTH) begin
          case ($urandom_range(0, 2))
            0: len = 16'd0;
            1: len = 16'(fsz - 11);
            default: len = 16'($urandom_range(fsz - 11, 65535));
          endcase
        end else if (flaw == FLAW_MAGIC) begin
          len = 16'($urandom_range(0, fsz));
        end else begin
          case ($urandom_range(0, 3))
            0: len = 16'd1;
            1: len = 16'(fsz - 12);
            default: len = 16'($urandom_range(1, fsz - 12));
          endcase
        end
        queue_packet(fsz, len, flaw, 0);
      end
      if (first_phase) begin
        hold_req = 1'b1;
        first_phase = 1'b0;
      end
      drain();
    end

    repeat (8) @(negedge clk);
    $display("summary: %0d bytes in, %0d payload bytes out, frames 13 to 120 bytes plus clamped",
             accepted_bytes, payload_count);
    $display("summary: packets ok %0d, bad magic %0d, bad length %0d, crc mismatch %0d",
             status_count[ST_OK], status_count[ST_BAD_MAGIC], status_count[ST_BAD_LEN],
             status_count[ST_BAD_CRC]);
    if (errors == 0 && due_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
